[rtl/core/xmiu_pkg.sv]
// shared types and constants of the x86 miscellaneous instruction unit
`default_nettype none

package xmiu_pkg;

    // opcode of one instruction item; codes 14 and 15 behave as nop
    typedef enum logic [3:0] {
        OP_CDQ   = 4'd0,
        OP_CWD   = 4'd1,
        OP_CWDE  = 4'd2,
        OP_BSWAP = 4'd3,
        OP_LAHF  = 4'd4,
        OP_STD   = 4'd5,
        OP_CLD   = 4'd6,
        OP_STC   = 4'd7,
        OP_CLC   = 4'd8,
        OP_AAA   = 4'd9,
        OP_AAS   = 4'd10,
        OP_AAM   = 4'd11,
        OP_AAD   = 4'd12,
        OP_NOP   = 4'd13
    } op_t;

    // stream widths
    localparam int OP_W        = 4;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 104;

    // bcd helpers: divide by ten as multiply by 205 and shift by 11, exact for 8 bits
    localparam logic [7:0] BCD_BASE       = 8'h0A;
    localparam logic [7:0] BCD_RECIP      = 8'd205;
    localparam int         BCD_RECIP_SHFT = 11;
    localparam logic [3:0] BCD_MAX_DIGIT  = 4'd9;
    localparam logic [7:0] BCD_ADJ        = 8'd6;

    // one instruction item
    typedef struct packed {
        op_t         op;
        logic [31:0] eax;
        logic [31:0] edx;
        logic [31:0] opd;
        logic        cf;
        logic        af;
        logic        pf;
        logic        zf;
        logic        sf;
        logic        df;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [31:0] eax;
        logic [31:0] edx;
        logic [31:0] opd;
        logic        cf;
        logic        af;
        logic        pf;
        logic        zf;
        logic        sf;
        logic        df;
    } res_item_t;

endpackage

`default_nettype wire

[rtl/core/xmiu_exec.sv]
// combinational execute logic for one instruction item
`default_nettype none

module xmiu_exec (
    input  xmiu_pkg::in_item_t  item_i,
    output xmiu_pkg::res_item_t res_o
);
    import xmiu_pkg::*;

    logic [7:0]  al;
    logic [7:0]  ah;
    logic [15:0] div_prod;
    logic [7:0]  aam_q;
    logic [7:0]  aam_r;
    logic [7:0]  aad_al;
    logic [7:0]  bcd_al;
    logic        bcd_adj;
    logic [7:0]  lahf_ah;

    // operand bytes and helper results
    always_comb begin
        al       = item_i.eax[7:0];
        ah       = item_i.eax[15:8];
        // al / 10 by reciprocal, remainder by back multiply
        div_prod = {8'h00, al} * {8'h00, BCD_RECIP};
        aam_q    = {3'b000, div_prod[15:BCD_RECIP_SHFT]};
        aam_r    = al - ((aam_q << 3) + (aam_q << 1));
        aad_al   = (ah << 3) + (ah << 1) + al;
        bcd_al   = (item_i.op == OP_AAM) ? aam_r : aad_al;
        bcd_adj  = (al[3:0] > BCD_MAX_DIGIT) || item_i.af;
        lahf_ah  = {item_i.sf, item_i.zf, 1'b0, item_i.af, 1'b0, item_i.pf, 1'b1, item_i.cf};
    end

    // per-opcode result
    always_comb begin
        res_o.eax = item_i.eax;
        res_o.edx = item_i.edx;
        res_o.opd = item_i.opd;
        res_o.cf  = item_i.cf;
        res_o.af  = item_i.af;
        res_o.pf  = item_i.pf;
        res_o.zf  = item_i.zf;
        res_o.sf  = item_i.sf;
        res_o.df  = item_i.df;
        unique case (item_i.op)
            OP_CDQ: begin
                res_o.edx = {32{item_i.eax[31]}};
            end
            OP_CWD: begin
                res_o.edx[15:0] = {16{item_i.eax[15]}};
            end
            OP_CWDE: begin
                res_o.eax[31:16] = {16{item_i.eax[15]}};
            end
            OP_BSWAP: begin
                res_o.opd = {item_i.opd[7:0], item_i.opd[15:8],
                             item_i.opd[23:16], item_i.opd[31:24]};
            end
            OP_LAHF: begin
                res_o.eax[15:8] = lahf_ah;
            end
            OP_STD: res_o.df = 1'b1;
            OP_CLD: res_o.df = 1'b0;
            OP_STC: res_o.cf = 1'b1;
            OP_CLC: res_o.cf = 1'b0;
            OP_AAA, OP_AAS: begin
                if (bcd_adj) begin
                    if (item_i.op == OP_AAA) begin
                        res_o.eax[7:0]  = {4'h0, al[3:0] + BCD_ADJ[3:0]};
                        res_o.eax[15:8] = ah + 8'd1;
                    end else begin
                        res_o.eax[7:0]  = {4'h0, al[3:0] - BCD_ADJ[3:0]};
                        res_o.eax[15:8] = ah - 8'd1;
                    end
                end else begin
                    res_o.eax[7:0] = {4'h0, al[3:0]};
                end
                res_o.af = bcd_adj;
                res_o.cf = bcd_adj;
                res_o.sf = 1'b0;
                res_o.zf = 1'b0;
                res_o.pf = 1'b0;
            end
            OP_AAM, OP_AAD: begin
                res_o.eax[7:0]  = bcd_al;
                res_o.eax[15:8] = (item_i.op == OP_AAM) ? aam_q : 8'h00;
                res_o.sf = bcd_al[7];
                res_o.zf = (bcd_al == 8'h00);
                res_o.pf = ~^bcd_al;
                res_o.af = 1'b0;
                res_o.cf = 1'b0;
            end
            default: begin
                // nop and unused codes pass everything through
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/x86_misc_instruction_unit.sv]
// top level of the x86 miscellaneous instruction unit: input and result registers
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser = opcode, s_tdata = registers and flags
// m_       out  m_tvalid/m_tready  m_tdata = registers and flags after the instruction
//
// one item per cycle sustained unless the output stalls; an accepted item passes the
// input register and execute logic, and m_tvalid rises once it is in the result register
// aresetn clears only the two stage valid bits
// a stalled result holds in the result register while the input register still
// takes one more item; s_tready drops only when both stages are full
`default_nettype none

module x86_misc_instruction_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // eax[31:0], edx[63:32], operand[95:64], carry 96, aux 97, parity 98,
    // zero 99, sign 100, direction 101, zero fill 103:102
    input  wire logic [xmiu_pkg::IN_TDATA_W-1:0]  s_tdata,
    // req_type[3:0]
    input  wire logic [xmiu_pkg::OP_W-1:0]        s_tuser,
    // result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // eax[31:0], edx[63:32], operand[95:64], carry 96, aux 97, parity 98,
    // zero 99, sign 100, direction 101, zero fill 103:102
    output logic [xmiu_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import xmiu_pkg::*;

    in_item_t  in_next;
    in_item_t  in_reg;
    logic      in_valid_reg;
    res_item_t res_next;
    res_item_t res_reg;
    logic      out_valid_reg;
    logic      out_ready;

    // unpack the input item
    always_comb begin
        in_next.op  = op_t'(s_tuser);
        in_next.eax = s_tdata[31:0];
        in_next.edx = s_tdata[63:32];
        in_next.opd = s_tdata[95:64];
        in_next.cf  = s_tdata[96];
        in_next.af  = s_tdata[97];
        in_next.pf  = s_tdata[98];
        in_next.zf  = s_tdata[99];
        in_next.sf  = s_tdata[100];
        in_next.df  = s_tdata[101];
    end

    // stage flow control
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= in_next;
        end
    end

    // execute logic
    xmiu_exec u_exec (
        .item_i (in_reg),
        .res_o  (res_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    // pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.df, res_reg.sf, res_reg.zf, res_reg.pf,
                       res_reg.af, res_reg.cf, res_reg.opd, res_reg.edx, res_reg.eax};

endmodule

`default_nettype wire
